// ===== rtl/core/wbps_pkg.sv =====
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and register codes for the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 5;
  localparam int MASK_W   = 16;
  localparam int PAT_W    = 64;
  localparam int RES_W    = 32;
  localparam int ADDR_W   = 5;
  localparam int NUM_PAT  = 16;

  localparam logic [1:0] REG_PATTERN_LOW  = 2'd0;
  localparam logic [1:0] REG_PATTERN_HIGH = 2'd1;
  localparam logic [1:0] REG_WILDCARD     = 2'd2;
  localparam logic [1:0] REG_LENGTH       = 2'd3;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic             found;
    logic [RES_W-1:0] offset;
  } result_t;

endpackage

// ===== rtl/core/wildcard_byte_pattern_scan_top.sv =====
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan_top
// Streaming scan for the first wildcard byte pattern match in each region.
// ----------------------------------------------------------------------------
// Bytes of a memory region arrive on the s_ channel, one word per byte, with
// s_tlast on the final byte. A row of cells holds the most recent bytes and
// compares each against its pattern byte in the same cycle the byte shifts
// in. The first match in a region yields one word on the m_ channel with
// m_tuser high and the match start offset in m_tdata; the rest of the region
// gives nothing. A region that ends without a match gives one word with
// m_tuser low and offset zero. The last byte always restarts the search.
// Throughput is one byte per cycle while s_tready is high, set by the combinational window compare.
// A result is registered in the output buffer before it shows on the m_ channel.
// A two-word output buffer keeps s_tready high while one result waits; when
// the receiver stalls with two results held, s_tready drops until one leaves.
// Reset clears the window, counter, match flag and buffer, sets the pattern
// length to one and all other registers to zero. The APB port takes writes
// at any time but should be written only while the scan is idle.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scan_top #(
  parameter int MAX_PATTERN = 16,
  parameter int OFFSET_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  // apb configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wbps_pkg::ADDR_W-1:0]    paddr,
  input  logic [wbps_pkg::PAT_W-1:0]     pwdata,
  output logic [wbps_pkg::PAT_W-1:0]     prdata,
  output logic                           pready,
  // input bytes
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] data_byte
  input  logic                           s_tlast,   // last_byte
  // results
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [31:0]                    m_tdata,   // [31:0] match_offset
  output logic                           m_tuser    // [0] found
);

  logic [wbps_pkg::PAT_W-1:0]  pat_low;
  logic [wbps_pkg::PAT_W-1:0]  pat_high;
  logic [wbps_pkg::MASK_W-1:0] wild;
  logic [wbps_pkg::LEN_W-1:0]  pat_len;

  logic                        cfg_write;
  logic [1:0]                  reg_sel;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = paddr[4:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_low  <= '0;
      pat_high <= '0;
      wild     <= '0;
      pat_len  <= wbps_pkg::LEN_W'(1);
    end else if (cfg_write) begin
      case (reg_sel)
        wbps_pkg::REG_PATTERN_LOW:  pat_low  <= pwdata;
        wbps_pkg::REG_PATTERN_HIGH: pat_high <= pwdata;
        wbps_pkg::REG_WILDCARD:     wild     <= pwdata[wbps_pkg::MASK_W-1:0];
        wbps_pkg::REG_LENGTH:       pat_len  <= pwdata[wbps_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      wbps_pkg::REG_PATTERN_LOW:  prdata = pat_low;
      wbps_pkg::REG_PATTERN_HIGH: prdata = pat_high;
      wbps_pkg::REG_WILDCARD:     prdata = wbps_pkg::PAT_W'(wild);
      wbps_pkg::REG_LENGTH:       prdata = wbps_pkg::PAT_W'(pat_len);
      default:                    prdata = '0;
    endcase
  end

  // length in use, held within one and the cell count
  logic [wbps_pkg::LEN_W-1:0] eff_len;

  always_comb begin
    if (pat_len == '0) begin
      eff_len = wbps_pkg::LEN_W'(1);
    end else if (pat_len > wbps_pkg::LEN_W'(MAX_PATTERN)) begin
      eff_len = wbps_pkg::LEN_W'(MAX_PATTERN);
    end else begin
      eff_len = pat_len;
    end
  end

  logic [2*wbps_pkg::PAT_W-1:0] pat_vec;
  assign pat_vec = {pat_high, pat_low};

  logic                   accept;
  wbps_pkg::cell_ctrl_t   ctrl;
  logic [MAX_PATTERN-1:0] hits;
  logic [7:0]             win [MAX_PATTERN];

  assign accept     = s_tvalid && s_tready;
  assign ctrl.shift = accept;
  assign ctrl.clear = s_tlast;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [wbps_pkg::LEN_W-1:0] pidx;
    logic [7:0]                 exp_byte;
    logic                       care;
    logic [7:0]                 din;

    // cell k compares the byte k words back, which lines up with pattern byte len-1-k
    assign pidx     = eff_len - wbps_pkg::LEN_W'(k) - wbps_pkg::LEN_W'(1);
    assign exp_byte = pat_vec[pidx[3:0]*8 +: 8];
    assign care     = (wbps_pkg::LEN_W'(k) < eff_len) && !wild[pidx[3:0]];

    if (k == 0) begin : g_head
      assign din = s_tdata;
    end else begin : g_link
      assign din = win[k-1];
    end

    wbps_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .din      (din),
      .expected (exp_byte),
      .care     (care),
      .dout     (win[k]),
      .hit      (hits[k])
    );
  end

  logic [OFFSET_BITS-1:0] byte_count;
  logic [OFFSET_BITS-1:0] byte_count_next;
  logic [OFFSET_BITS-1:0] len_ext;
  logic                   matched;
  logic                   hit_now;
  logic                   push;
  logic                   buf_ready;
  wbps_pkg::result_t      res;
  wbps_pkg::result_t      res_out;

  assign byte_count_next = (byte_count == '1) ? byte_count : byte_count + OFFSET_BITS'(1);
  assign len_ext         = OFFSET_BITS'(eff_len);
  assign hit_now         = !matched && (byte_count_next >= len_ext) && (&hits);
  assign push            = accept && (hit_now || (s_tlast && !matched));
  assign res.found       = hit_now;
  assign res.offset      = hit_now ? wbps_pkg::RES_W'(byte_count_next - len_ext) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      matched    <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        byte_count <= '0;
        matched    <= 1'b0;
      end else begin
        byte_count <= byte_count_next;
        if (hit_now) begin
          matched <= 1'b1;
        end
      end
    end
  end

  wbps_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (res),
    .in_ready  (buf_ready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .dout      (res_out)
  );

  assign s_tready = buf_ready;
  assign m_tdata  = res_out.offset;
  assign m_tuser  = res_out.found;

endmodule

// ===== rtl/core/wbps_cell.sv =====
// ----------------------------------------------------------------------------
// wbps_cell
// One window byte of the scan chain with its pattern compare.
// ----------------------------------------------------------------------------
module wbps_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  wbps_pkg::cell_ctrl_t         ctrl,
  input  logic [wbps_pkg::BYTE_W-1:0]  din,
  input  logic [wbps_pkg::BYTE_W-1:0]  expected,
  input  logic                         care,
  output logic [wbps_pkg::BYTE_W-1:0]  dout,
  output logic                         hit
);

  logic [wbps_pkg::BYTE_W-1:0] held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (ctrl.shift) begin
      if (ctrl.clear) begin
        held <= '0;
      end else begin
        held <= din;
      end
    end
  end

  // compare against the byte that enters this cell on the current word
  assign hit  = !care || (din == expected);
  assign dout = held;

endmodule

// ===== rtl/core/wbps_obuf.sv =====
// ----------------------------------------------------------------------------
// wbps_obuf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module wbps_obuf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  wbps_pkg::result_t   din,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output wbps_pkg::result_t   dout
);

  wbps_pkg::result_t main_word;
  wbps_pkg::result_t skid_word;
  logic              main_valid;
  logic              skid_valid;
  logic              pop;

  assign pop = main_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        main_word <= skid_word;
      end else if (push) begin
        main_word <= din;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_word <= din;
      end else begin
        main_word <= din;
      end
    end
  end

  assign in_ready  = !skid_valid;
  assign out_valid = main_valid;
  assign dout      = main_word;

`ifndef SYNTHESIS
  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid word held without output word");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    (push && main_valid && !out_ready) |=> skid_valid)
    else $error("result lost while output stalled");

  a_skid_moves_up: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_ready) |=> (main_valid && dout == $past(skid_word)))
    else $error("skid word not forwarded");
`endif

endmodule
